[sv/ipfc_pkg.sv]
// Shared types, codes and constants of the interlocked pulse fire controller.
package ipfc_pkg;

    localparam int CHANNELS  = 3;
    localparam int SHOWN     = (CHANNELS < 3) ? CHANNELS : 3;
    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 32;

    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_FIRE  = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    localparam logic [2:0] ST_OK            = 3'd0;
    localparam logic [2:0] ST_BAD_CHANNEL   = 3'd1;
    localparam logic [2:0] ST_FAULT_LATCHED = 3'd2;
    localparam logic [2:0] ST_FAULT_ACTIVE  = 3'd3;
    localparam logic [2:0] ST_NOT_ARMED     = 3'd4;
    localparam logic [2:0] ST_NO_CONTINUITY = 3'd5;
    localparam logic [2:0] ST_ALREADY_FIRING = 3'd6;
    localparam logic [2:0] ST_FAULT_STILL   = 3'd7;

    localparam logic [1:0] REG_ARM_THRESHOLD  = 2'd0;
    localparam logic [1:0] REG_CONT_THRESHOLD = 2'd1;
    localparam logic [1:0] REG_PULSE_TICKS    = 2'd2;
    localparam logic [1:0] REG_CLEAR_QUIET    = 2'd3;

    localparam logic [11:0] ARM_THRESHOLD_RST  = 12'd2048;
    localparam logic [11:0] CONT_THRESHOLD_RST = 12'd1024;
    localparam logic [15:0] PULSE_TICKS_RST    = 16'd1000;
    localparam logic [7:0]  CLEAR_QUIET_RST    = 8'd2;

    typedef struct packed {
        logic [11:0] arm_threshold;
        logic [11:0] continuity_threshold;
        logic [15:0] pulse_ticks;
        logic [7:0]  clear_quiet_ticks;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  channel;
        logic        fault_line_low;
        logic [11:0] arm_raw;
        logic [11:0] continuity_raw;
    } item_t;

    typedef struct packed {
        logic [2:0] status;
        logic [2:0] outputs_on;
        logic       fault_latched;
        logic       fault_new;
    } result_t;

endpackage

[sv/ipfc_if.sv]
// Valid/ready channel interfaces for input items and result items.
interface ipfc_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [2:0]  channel;
    logic        fault_line_low;
    logic [11:0] arm_raw;
    logic [11:0] continuity_raw;

    modport source (output valid, output kind, output channel, output fault_line_low,
                    output arm_raw, output continuity_raw, input ready);
    modport sink   (input valid, input kind, input channel, input fault_line_low,
                    input arm_raw, input continuity_raw, output ready);
endinterface

interface ipfc_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [2:0] outputs_on;
    logic       fault_latched;
    logic       fault_new;

    modport source (output valid, output status, output outputs_on, output fault_latched,
                    output fault_new, input ready);
    modport sink   (input valid, input status, input outputs_on, input fault_latched,
                    input fault_new, output ready);
endinterface

[sv/ipfc_regs.sv]
// APB configuration registers of the pulse fire controller.
module ipfc_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ipfc_pkg::ADDR_W-1:0] paddr,
    input  logic [ipfc_pkg::DATA_W-1:0] pwdata,
    output logic [ipfc_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output ipfc_pkg::cfg_t             cfg
);
    import ipfc_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[ADDR_W-1:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.arm_threshold        <= ARM_THRESHOLD_RST;
            cfg_reg.continuity_threshold <= CONT_THRESHOLD_RST;
            cfg_reg.pulse_ticks          <= PULSE_TICKS_RST;
            cfg_reg.clear_quiet_ticks    <= CLEAR_QUIET_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_ARM_THRESHOLD:  cfg_reg.arm_threshold        <= pwdata[11:0];
                REG_CONT_THRESHOLD: cfg_reg.continuity_threshold <= pwdata[11:0];
                REG_PULSE_TICKS:    cfg_reg.pulse_ticks          <= pwdata[15:0];
                REG_CLEAR_QUIET:    cfg_reg.clear_quiet_ticks    <= pwdata[7:0];
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_ARM_THRESHOLD:  prdata = {20'd0, cfg_reg.arm_threshold};
            REG_CONT_THRESHOLD: prdata = {20'd0, cfg_reg.continuity_threshold};
            REG_PULSE_TICKS:    prdata = {16'd0, cfg_reg.pulse_ticks};
            REG_CLEAR_QUIET:    prdata = {24'd0, cfg_reg.clear_quiet_ticks};
            default:            prdata = '0;
        endcase
    end

endmodule

[sv/ipfc_engine.sv]
// Interlock state and the per-item decision logic of the pulse fire controller.
module ipfc_engine (
    input  logic              clk,
    input  logic              rst_n,
    input  ipfc_pkg::cfg_t    cfg,
    input  logic              step,
    input  ipfc_pkg::item_t   item,
    output ipfc_pkg::result_t res
);
    import ipfc_pkg::*;

    localparam logic [3:0] CHAN_LIMIT = 4'(CHANNELS);

    logic [CHANNELS-1:0]        pulse_active_reg, pulse_active_next;
    logic [CHANNELS-1:0][15:0]  ticks_left_reg, ticks_left_next;
    logic                       fault_flag_reg, fault_flag_next;
    logic [7:0]                 quiet_count_reg, quiet_count_next;

    logic [2:0]  status;
    logic        channel_bad;
    logic        chan_busy;
    logic [15:0] load_len;
    logic [15:0] dec_val;
    logic [2:0]  mask;

    assign channel_bad = {1'b0, item.channel} >= CHAN_LIMIT;
    assign load_len    = (cfg.pulse_ticks == 16'd0) ? 16'd1 : cfg.pulse_ticks;

    always_comb
    begin
        chan_busy = 1'b0;
        for (int i = 0; i < CHANNELS; i++)
        begin
            if (item.channel == 3'(i) && pulse_active_reg[i])
            begin
                chan_busy = 1'b1;
            end
        end
    end

    always_comb
    begin
        pulse_active_next = pulse_active_reg;
        ticks_left_next   = ticks_left_reg;
        fault_flag_next   = fault_flag_reg;
        quiet_count_next  = quiet_count_reg;
        status            = ST_OK;
        dec_val           = '0;

        case (item.kind)
            KIND_TICK:
            begin
                for (int i = 0; i < CHANNELS; i++)
                begin
                    if (pulse_active_reg[i])
                    begin
                        dec_val = (ticks_left_reg[i] != 16'd0) ? ticks_left_reg[i] - 16'd1
                                                               : 16'd0;
                        ticks_left_next[i] = dec_val;
                        if (dec_val == 16'd0)
                        begin
                            pulse_active_next[i] = 1'b0;
                        end
                    end
                end
                if (!item.fault_line_low && quiet_count_reg != 8'hFF)
                begin
                    quiet_count_next = quiet_count_reg + 8'd1;
                end
            end
            KIND_FIRE:
            begin
                if (channel_bad)
                    status = ST_BAD_CHANNEL;
                else if (fault_flag_reg)
                    status = ST_FAULT_LATCHED;
                else if (item.fault_line_low)
                    status = ST_FAULT_ACTIVE;
                else if (!(item.arm_raw > cfg.arm_threshold))
                    status = ST_NOT_ARMED;
                else if (!(item.continuity_raw > cfg.continuity_threshold))
                    status = ST_NO_CONTINUITY;
                else if (chan_busy)
                    status = ST_ALREADY_FIRING;
                else
                begin
                    for (int i = 0; i < CHANNELS; i++)
                    begin
                        if (item.channel == 3'(i))
                        begin
                            pulse_active_next[i] = 1'b1;
                            ticks_left_next[i]   = load_len;
                        end
                    end
                end
            end
            KIND_CLEAR:
            begin
                if (item.fault_line_low || quiet_count_reg < cfg.clear_quiet_ticks)
                    status = ST_FAULT_STILL;
                else
                    fault_flag_next = 1'b0;
            end
            default:
            begin
                status = ST_OK;
            end
        endcase

        // A low fault line overrides whatever the request did.
        if (item.fault_line_low)
        begin
            fault_flag_next   = 1'b1;
            quiet_count_next  = '0;
            pulse_active_next = '0;
            ticks_left_next   = '0;
        end
    end

    always_comb
    begin
        mask = '0;
        for (int i = 0; i < SHOWN; i++)
        begin
            mask[i] = pulse_active_next[i];
        end
    end

    assign res.status        = status;
    assign res.outputs_on    = mask;
    assign res.fault_latched = fault_flag_next;
    assign res.fault_new     = item.fault_line_low && !fault_flag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_active_reg <= '0;
            ticks_left_reg   <= '0;
            fault_flag_reg   <= 1'b0;
            quiet_count_reg  <= '0;
        end
        else if (step)
        begin
            pulse_active_reg <= pulse_active_next;
            ticks_left_reg   <= ticks_left_next;
            fault_flag_reg   <= fault_flag_next;
            quiet_count_reg  <= quiet_count_next;
        end
    end

`ifndef ASSERT_OFF
    // No output may be on while the fault latch is set.
    a_no_pulse_in_fault: assert property (@(posedge clk) disable iff (!rst_n)
        fault_flag_reg |-> (pulse_active_reg == '0))
        else $error("pulse active while fault latched");

    // A committed tick on channel 0's last remaining tick releases channel 0.
    a_active_has_ticks: assert property (@(posedge clk) disable iff (!rst_n)
        step && item.kind == KIND_TICK && pulse_active_reg[0] && ticks_left_reg[0] == 16'd1
        |=> !pulse_active_reg[0])
        else $error("channel 0 did not release at end of pulse");

    // A committed low fault line leaves the latch set and the quiet count at zero.
    a_fault_latches: assert property (@(posedge clk) disable iff (!rst_n)
        step && item.fault_line_low |=> fault_flag_reg && quiet_count_reg == 8'd0)
        else $error("fault line low did not latch the fault");
`endif

endmodule

[sv/interlocked_pulse_fire_controller_core.sv]
// Top level of the interlocked pulse fire controller: input stage, engine and result stage.
//
// Each beat on item_in is a millisecond tick, a fire request or a clear-fault request
// with fresh samples of the fault line, arm sense and channel continuity; every beat
// yields exactly one beat on result_out. The block takes one item per clock cycle unless
// result_out stalls: an accepted item sits in the input register while the single-pass
// interlock logic evaluates it, and the result register captures the outcome once the
// result stage is free. A result that is not taken holds the item behind it in the input
// register, so the input stalls only when both stages are full. The result register lets
// the next item be accepted while a finished result still waits. Each item is judged
// against the state left by the item before it. Configuration registers sit on the APB
// port at byte addresses 0, 4, 8 and 12; the user must write them only while idle, and
// the block itself does not enforce this.
module interlocked_pulse_fire_controller_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ipfc_pkg::ADDR_W-1:0] paddr,
    input  logic [ipfc_pkg::DATA_W-1:0] pwdata,
    output logic [ipfc_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    ipfc_item_if.sink                   item_in,
    ipfc_result_if.source               result_out
);
    import ipfc_pkg::*;

    cfg_t    cfg;
    item_t   item_reg;
    logic    item_valid_reg;
    result_t res;
    result_t res_reg;
    logic    res_valid_reg;
    logic    advance;

    assign advance       = item_valid_reg && (!res_valid_reg || result_out.ready);
    assign item_in.ready = !item_valid_reg || advance;

    ipfc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ipfc_engine u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .step  (advance),
        .item  (item_reg),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (item_in.ready)
            begin
                item_valid_reg <= item_in.valid;
            end
            if (advance)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result_out.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_in.ready && item_in.valid)
        begin
            item_reg.kind           <= item_in.kind;
            item_reg.channel        <= item_in.channel;
            item_reg.fault_line_low <= item_in.fault_line_low;
            item_reg.arm_raw        <= item_in.arm_raw;
            item_reg.continuity_raw <= item_in.continuity_raw;
        end
        if (advance)
        begin
            res_reg <= res;
        end
    end

    assign result_out.valid         = res_valid_reg;
    assign result_out.status        = res_reg.status;
    assign result_out.outputs_on    = res_reg.outputs_on;
    assign result_out.fault_latched = res_reg.fault_latched;
    assign result_out.fault_new     = res_reg.fault_new;

`ifndef ASSERT_OFF
    // An empty input stage always takes a new beat.
    a_empty_stage_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !item_valid_reg |-> item_in.ready)
        else $error("input stage empty but not ready");

    // A freshly latched fault shows up with the latch set and every output off.
    a_fault_new_outputs_off: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.fault_new |-> res_reg.fault_latched && res_reg.outputs_on == '0)
        else $error("new fault reported with outputs still on");

    // An item in the input stage moves on in the cycle the result stage frees up.
    a_item_drains: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg && (!res_valid_reg || result_out.ready) |=> res_valid_reg)
        else $error("item did not move into the result stage");
`endif

endmodule
